[design/hbp_pkg.sv]
// Shared constants and types for the Huffman encoder bit packer.
package hbp_pkg;

    localparam int SYMBOL_COUNT  = 256;
    localparam int MAX_CODE_BITS = 32;

    localparam int OP_W      = 2;
    localparam int SYM_W     = 8;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int S_TDATA_W = ((SYM_W + CODE_W + LEN_W + 7) / 8) * 8;

    localparam int SYM_AW  = $clog2(SYMBOL_COUNT);
    localparam int ENTRY_W = MAX_CODE_BITS + LEN_W;
    localparam int WORD_W  = MAX_CODE_BITS + BYTE_W;
    localparam int TOT_W   = $clog2(WORD_W);
    localparam int NB_W    = TOT_W - 3;

    localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_CODE_BITS);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

endpackage

[design/hbp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module hbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/huffman_encoder_bit_packer.sv]
// Top level of the Huffman encoder with its MSB-first byte packer.
//
// Input beats carry an operation in s_axis_tuser: load a table entry, encode a
// symbol, or flush the partial byte. Output beats carry one packed byte each, and
// m_axis_tlast marks the final byte caused by one input beat. Loads, zero-length
// symbols and flushes of an empty packer produce no output beat.
// An input beat is registered while the code table is read, the code is merged
// with the packer in the next cycle and registered in the byte stage, and the
// bytes then leave one per cycle through the output register while the receiver
// takes them. The block takes one input beat per cycle as long as each item
// yields at most one byte and the receiver does not stall; an item with more
// bytes holds the byte stage until its last byte moves to the output register,
// and the items behind it wait, as the output is one byte wide. A 32-bit code
// yields up to four bytes. When the receiver stalls, the output register holds
// its byte and the stages behind it fill up before s_axis_tready falls.
// Reset clears the packer, empties all stages and marks every table entry as
// length zero. Code words are kept in a 256-entry RAM; a bank of valid flags
// stands in for the zero lengths, so no clearing pass is needed.
module huffman_encoder_bit_packer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // symbol [7:0], code_bits [39:8], code_length [45:40], zero fill above
    input  logic [hbp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // op [1:0]
    input  logic [hbp_pkg::OP_W-1:0]     s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_byte [7:0]
    output logic [hbp_pkg::BYTE_W-1:0]   m_axis_tdata,
    output logic                         m_axis_tlast
);

    import hbp_pkg::*;

    logic                     in_accept;
    op_t                      in_op;
    logic [SYM_W-1:0]         in_sym;
    logic [CODE_W-1:0]        in_code;
    logic [LEN_W-1:0]         in_len;
    logic [LEN_W-1:0]         in_len_sat;
    logic                     in_range;
    logic [SYM_AW-1:0]        in_idx;
    logic                     ram_we;
    logic                     ram_re;
    logic [ENTRY_W-1:0]       ram_wdata;
    logic [ENTRY_W-1:0]       ram_rdata;

    logic [SYMBOL_COUNT-1:0]  valid_reg;
    logic                     s1_valid_reg;
    op_t                      s1_op_reg;
    logic                     s1_hit_reg;

    logic [BYTE_W-1:0]        pack_byte_reg;
    logic [2:0]               pack_count_reg;
    logic [BYTE_W-1:0]        pack_byte_next;
    logic [2:0]               pack_count_next;

    logic [MAX_CODE_BITS-1:0] rd_code;
    logic [LEN_W-1:0]         rd_len;
    logic [LEN_W-1:0]         len_eff;
    logic [MAX_CODE_BITS-1:0] code_left;
    logic [WORD_W-1:0]        head_word;
    logic [WORD_W-1:0]        enc_word;
    logic [WORD_W-1:0]        enc_shifted;
    logic [TOT_W-1:0]         enc_total;
    logic [NB_W-1:0]          enc_bytes;
    logic [WORD_W-1:0]        item_word;
    logic [NB_W-1:0]          item_bytes;
    logic                     s1_advance;

    logic                     e_valid_reg;
    logic [WORD_W-1:0]        e_word_reg;
    logic [NB_W-1:0]          e_left_reg;
    logic                     e_send;
    logic                     e_done;
    logic                     e_avail;
    logic                     e_load;
    logic                     out_free;

    logic                     m_valid_reg;
    logic [BYTE_W-1:0]        m_data_reg;
    logic                     m_last_reg;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign in_op      = op_t'(s_axis_tuser);
    assign in_sym     = s_axis_tdata[SYM_W-1:0];
    assign in_code    = s_axis_tdata[SYM_W +: CODE_W];
    assign in_len     = s_axis_tdata[SYM_W + CODE_W +: LEN_W];
    assign in_len_sat = (in_len > LEN_MAX) ? LEN_MAX : in_len;
    assign in_range   = {1'b0, in_sym} < SYM_LIMIT;
    assign in_idx     = in_sym[SYM_AW-1:0];

    assign ram_we    = in_accept && (in_op == OP_LOAD) && in_range;
    assign ram_re    = in_accept && (in_op == OP_ENCODE);
    assign ram_wdata = {in_len_sat, in_code[MAX_CODE_BITS-1:0]};

    hbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    assign rd_code = ram_rdata[MAX_CODE_BITS-1:0];
    assign rd_len  = ram_rdata[MAX_CODE_BITS +: LEN_W];

    // The code is left aligned so that bits above its length fall off, then it is
    // placed right after the bits already gathered in the packer.
    assign len_eff     = s1_hit_reg ? rd_len : '0;
    assign code_left   = rd_code << (LEN_MAX - len_eff);
    assign head_word   = {pack_byte_reg, {MAX_CODE_BITS{1'b0}}};
    assign enc_word    = head_word | ({code_left, {BYTE_W{1'b0}}} >> pack_count_reg);
    assign enc_total   = TOT_W'(pack_count_reg) + TOT_W'(len_eff);
    assign enc_bytes   = enc_total[TOT_W-1:3];
    assign enc_shifted = enc_word << {enc_bytes, 3'b000};

    always_comb begin
        item_word       = head_word;
        item_bytes      = '0;
        pack_byte_next  = pack_byte_reg;
        pack_count_next = pack_count_reg;
        case (s1_op_reg)
            OP_ENCODE: begin
                item_word       = enc_word;
                item_bytes      = enc_bytes;
                pack_byte_next  = enc_shifted[WORD_W-1 -: BYTE_W];
                pack_count_next = enc_total[2:0];
            end
            OP_FLUSH: begin
                item_bytes      = (pack_count_reg != 3'd0) ? NB_W'(1) : '0;
                pack_byte_next  = '0;
                pack_count_next = '0;
            end
            default: begin
                item_bytes = '0;
            end
        endcase
    end

    assign out_free   = !m_valid_reg || m_axis_tready;
    assign e_send     = e_valid_reg && out_free;
    assign e_done     = e_send && (e_left_reg == NB_W'(1));
    assign e_avail    = !e_valid_reg || e_done;
    assign s1_advance = s1_valid_reg && ((item_bytes == '0) || e_avail);
    assign e_load     = s1_advance && (item_bytes != '0);

    assign s_axis_tready = !s1_valid_reg || s1_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            pack_byte_reg  <= '0;
            pack_count_reg <= '0;
            e_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (ram_we) begin
                valid_reg[in_idx] <= 1'b1;
            end
            if (s_axis_tready) begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s1_advance) begin
                pack_byte_reg  <= pack_byte_next;
                pack_count_reg <= pack_count_next;
            end
            if (e_load) begin
                e_valid_reg <= 1'b1;
            end else if (e_done) begin
                e_valid_reg <= 1'b0;
            end
            if (e_send) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_op_reg  <= in_op;
            s1_hit_reg <= (in_op == OP_ENCODE) && in_range && valid_reg[in_idx];
        end
        if (e_load) begin
            e_word_reg <= item_word;
            e_left_reg <= item_bytes;
        end else if (e_send) begin
            e_word_reg <= e_word_reg << BYTE_W;
            e_left_reg <= e_left_reg - NB_W'(1);
        end
        if (e_send) begin
            m_data_reg <= e_word_reg[WORD_W-1 -: BYTE_W];
            m_last_reg <= (e_left_reg == NB_W'(1));
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

[design/hbp_checker.sv]
// Port-level assertions for the Huffman encoder bit packer, bound to the top level.
module hbp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [hbp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic [hbp_pkg::OP_W-1:0]      s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [hbp_pkg::BYTE_W-1:0]    m_axis_tdata,
    input logic                          m_axis_tlast
);

    import hbp_pkg::*;

    // A stalled output beat keeps its byte and its last flag.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // The bytes of one item leave without gaps once the first one is taken.
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside the bytes of one item");

    // The output stays idle after reset until a beat has passed the stages in front of it.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("output beat too soon after reset");

    // The input side is open right after reset.
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind huffman_encoder_bit_packer hbp_checker u_hbp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
